>>> sv/ttcw_pkg.sv
// Package for the text terminal cell writer: character codes, word widths,
// operation and state encodings. No dependencies.
package ttcw_pkg;

    // Fixed field widths
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int CELL_ADDR_W = 11;

    // Most cell writes one input byte may cause
    localparam int MAX_RESULTS = 8;

    // Attribute after reset: light grey on black
    localparam logic [ATTR_W-1:0] TEXT_COLOR_RESET = 8'h07;

    // Control codes and the blank glyph
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // What the sequencer does with the held byte
    typedef enum logic [2:0] {
        OP_PUT,
        OP_TAB,
        OP_BS,
        OP_FF,
        OP_LF,
        OP_CR
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAIT
    } state_t;

endpackage

>>> sv/text_terminal_cell_writer.sv
// Text terminal cell writer: turns a stream of character bytes into cell
// writes for a character screen. Depends on ttcw_pkg.
//
// Usage
//   Input channel : char_in with in_valid / in_stall. A byte is taken when
//                   in_valid is high and in_stall is low.
//   Output channel: cell_address, cell_glyph, cell_attr, fill_all and
//                   last_write with out_valid / out_stall. last_write marks
//                   the final word caused by one input byte.
//   Configuration : cfg_wr_en / cfg_wr_data load the attribute byte, to be
//                   written only while the block is idle.
//   Timing        : one byte at a time. A printable byte, backspace or form
//                   feed gives its word through the execute state and the
//                   output register (a backspace at the origin gives none),
//                   and the block is ready again the cycle after that word
//                   is taken. A tab gives one word per space, each through
//                   the execute and wait states. Newline and carriage return
//                   give no word; each step uses the shared address adder.
//   Reset         : cursor home, attribute 0x07, no word pending.
//   Stall         : a word held by out_stall stays on the output unchanged;
//                   in_stall stays high until every word of the byte is gone.
module text_terminal_cell_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input bytes
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ttcw_pkg::CHAR_W-1:0]     char_in,
    // cell writes
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ttcw_pkg::CELL_ADDR_W-1:0] cell_address,
    output logic [ttcw_pkg::CHAR_W-1:0]     cell_glyph,
    output logic [ttcw_pkg::ATTR_W-1:0]     cell_attr,
    output logic                            fill_all,
    output logic                            last_write,
    // attribute register
    input  logic                            cfg_wr_en,
    input  logic [ttcw_pkg::ATTR_W-1:0]     cfg_wr_data
);

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PH_W    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int CNT_W   = $clog2(TAB_STOP + 1);
    localparam int TAB_MAX = (TAB_STOP > ttcw_pkg::MAX_RESULTS) ?
                             ttcw_pkg::MAX_RESULTS : TAB_STOP;
    localparam int AW      = ttcw_pkg::CELL_ADDR_W;

    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [PH_W-1:0]  LAST_PH   = PH_W'(TAB_STOP - 1);
    localparam logic [PH_W-1:0]  END_PH    = PH_W'((COLUMNS - 1) % TAB_STOP);

    ttcw_pkg::state_t state_reg, state_next;
    ttcw_pkg::op_t    op_reg, op_next;

    logic [ttcw_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [CNT_W-1:0]            tab_cnt_reg, tab_cnt_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [PH_W-1:0]             phase_reg, phase_next;    // column mod tab stop
    logic [AW-1:0]               addr_reg, addr_next;      // linear cell index
    logic [ttcw_pkg::ATTR_W-1:0] color_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [AW-1:0]               out_addr_reg, out_addr_next;
    logic [ttcw_pkg::CHAR_W-1:0] out_glyph_reg, out_glyph_next;
    logic [ttcw_pkg::ATTR_W-1:0] out_attr_reg, out_attr_next;
    logic                        out_fill_reg, out_fill_next;
    logic                        out_last_reg, out_last_next;

    logic             accept;
    logic             at_last_col;
    logic             at_last_row;
    logic             at_origin;
    logic [AW-1:0]    col_ext;
    logic [AW-1:0]    addend;
    logic [AW-1:0]    addr_sum;
    logic [CNT_W-1:0] spaces;
    ttcw_pkg::op_t    op_dec;

    assign accept      = in_valid && (state_reg == ttcw_pkg::ST_IDLE);
    assign at_last_col = (col_reg == LAST_COL);
    assign at_last_row = (row_reg == LAST_ROW);
    assign at_origin   = (row_reg == '0) && (col_reg == '0);
    assign col_ext     = AW'(col_reg);

    // Spaces up to the next tab stop, capped
    always_comb
    begin
        spaces = CNT_W'(TAB_STOP) - CNT_W'(phase_reg);
        if (spaces > CNT_W'(TAB_MAX))
        begin
            spaces = CNT_W'(TAB_MAX);
        end
    end

    // Byte decode
    always_comb
    begin
        case (char_in)
            ttcw_pkg::CH_LF:  op_dec = ttcw_pkg::OP_LF;
            ttcw_pkg::CH_CR:  op_dec = ttcw_pkg::OP_CR;
            ttcw_pkg::CH_TAB: op_dec = ttcw_pkg::OP_TAB;
            ttcw_pkg::CH_BS:  op_dec = ttcw_pkg::OP_BS;
            ttcw_pkg::CH_FF:  op_dec = ttcw_pkg::OP_FF;
            default:          op_dec = ttcw_pkg::OP_PUT;
        endcase
    end

    // Shared address adder: operand picked by the current operation
    always_comb
    begin
        case (op_reg)
            ttcw_pkg::OP_PUT, ttcw_pkg::OP_TAB: addend = AW'(1);
            ttcw_pkg::OP_BS:                    addend = '1;
            ttcw_pkg::OP_LF:                    addend = AW'(COLUMNS) - col_ext;
            ttcw_pkg::OP_CR:                    addend = AW'(0) - col_ext;
            default:                            addend = '0;
        endcase
        addr_sum = addr_reg + addend;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ttcw_pkg::ST_EXEC;
                end
            end
            ttcw_pkg::ST_EXEC:
            begin
                case (op_reg)
                    ttcw_pkg::OP_LF, ttcw_pkg::OP_CR: state_next = ttcw_pkg::ST_IDLE;
                    ttcw_pkg::OP_BS:
                    begin
                        state_next = at_origin ? ttcw_pkg::ST_IDLE : ttcw_pkg::ST_WAIT;
                    end
                    default: state_next = ttcw_pkg::ST_WAIT;
                endcase
            end
            ttcw_pkg::ST_WAIT:
            begin
                if (!out_stall)
                begin
                    if ((op_reg == ttcw_pkg::OP_TAB) && (tab_cnt_reg != '0))
                    begin
                        state_next = ttcw_pkg::ST_EXEC;
                    end
                    else
                    begin
                        state_next = ttcw_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = ttcw_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next        = op_reg;
        char_next      = char_reg;
        tab_cnt_next   = tab_cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_glyph_next = out_glyph_reg;
        out_attr_next  = out_attr_reg;
        out_fill_next  = out_fill_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ttcw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = op_dec;
                    char_next    = char_in;
                    tab_cnt_next = spaces;
                end
            end
            ttcw_pkg::ST_EXEC:
            begin
                case (op_reg)
                    ttcw_pkg::OP_PUT, ttcw_pkg::OP_TAB:
                    begin
                        out_valid_next = 1'b1;
                        out_addr_next  = addr_reg;
                        out_attr_next  = color_reg;
                        out_fill_next  = 1'b0;
                        if (op_reg == ttcw_pkg::OP_TAB)
                        begin
                            out_glyph_next = ttcw_pkg::CH_SPACE;
                            out_last_next  = (tab_cnt_reg == CNT_W'(1));
                            tab_cnt_next   = tab_cnt_reg - CNT_W'(1);
                        end
                        else
                        begin
                            out_glyph_next = char_reg;
                            out_last_next  = 1'b1;
                        end
                        // advance the cursor, wrapping at line and screen end
                        if (at_last_col)
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            row_next   = at_last_row ? '0 : row_reg + ROW_W'(1);
                            addr_next  = at_last_row ? '0 : addr_sum;
                        end
                        else
                        begin
                            col_next   = col_reg + COL_W'(1);
                            phase_next = (phase_reg == LAST_PH) ? '0 : phase_reg + PH_W'(1);
                            addr_next  = addr_sum;
                        end
                    end
                    ttcw_pkg::OP_BS:
                    begin
                        if (!at_origin)
                        begin
                            if (col_reg != '0)
                            begin
                                col_next   = col_reg - COL_W'(1);
                                phase_next = (phase_reg == '0) ? LAST_PH : phase_reg - PH_W'(1);
                            end
                            else
                            begin
                                row_next   = row_reg - ROW_W'(1);
                                col_next   = LAST_COL;
                                phase_next = END_PH;
                            end
                            addr_next      = addr_sum;
                            out_valid_next = 1'b1;
                            out_addr_next  = addr_sum;
                            out_glyph_next = ttcw_pkg::CH_SPACE;
                            out_attr_next  = color_reg;
                            out_fill_next  = 1'b0;
                            out_last_next  = 1'b1;
                        end
                    end
                    ttcw_pkg::OP_FF:
                    begin
                        row_next       = '0;
                        col_next       = '0;
                        phase_next     = '0;
                        addr_next      = '0;
                        out_valid_next = 1'b1;
                        out_addr_next  = '0;
                        out_glyph_next = ttcw_pkg::CH_SPACE;
                        out_attr_next  = color_reg;
                        out_fill_next  = 1'b1;
                        out_last_next  = 1'b1;
                    end
                    ttcw_pkg::OP_LF:
                    begin
                        col_next   = '0;
                        phase_next = '0;
                        row_next   = at_last_row ? '0 : row_reg + ROW_W'(1);
                        addr_next  = at_last_row ? '0 : addr_sum;
                    end
                    ttcw_pkg::OP_CR:
                    begin
                        col_next   = '0;
                        phase_next = '0;
                        addr_next  = addr_sum;
                    end
                    default:
                    begin
                        op_next = ttcw_pkg::OP_PUT;
                    end
                endcase
            end
            ttcw_pkg::ST_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttcw_pkg::ST_IDLE;
            op_reg        <= ttcw_pkg::OP_PUT;
            tab_cnt_reg   <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            addr_reg      <= '0;
            color_reg     <= ttcw_pkg::TEXT_COLOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            tab_cnt_reg   <= tab_cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                color_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        out_addr_reg  <= out_addr_next;
        out_glyph_reg <= out_glyph_next;
        out_attr_reg  <= out_attr_next;
        out_fill_reg  <= out_fill_next;
        out_last_reg  <= out_last_next;
    end

    assign in_stall     = (state_reg != ttcw_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign cell_address = out_addr_reg;
    assign cell_glyph   = out_glyph_reg;
    assign cell_attr    = out_attr_reg;
    assign fill_all     = out_fill_reg;
    assign last_write   = out_last_reg;

endmodule

>>> sv/ttcw_checker.sv
// Port-level checks for the text terminal cell writer, bound to the top level.
// Depends on ttcw_pkg and text_terminal_cell_writer.
module ttcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [ttcw_pkg::CELL_ADDR_W-1:0] cell_address,
    input logic [ttcw_pkg::CHAR_W-1:0]      cell_glyph,
    input logic                             fill_all,
    input logic                             last_write
);

    localparam int CELLS = COLUMNS * ROWS;

    // A held word keeps its address and glyph
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_address) && $stable(cell_glyph))
        else $error("stalled word changed");

    // No new byte is taken while a word is pending
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input ready while a word is pending");

    // A word never appears in the cycle after a byte is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("word too early after acceptance");

    // A fill command is a lone blank at the origin
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fill_all |->
            (cell_address == '0) && (cell_glyph == ttcw_pkg::CH_SPACE) && last_write)
        else $error("malformed fill command");

    // Addresses stay on the screen when the screen fits the address field
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CELLS > 2048) || (int'(cell_address) < CELLS))
        else $error("cell address off screen");

endmodule

bind text_terminal_cell_writer ttcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
) u_ttcw_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_address(cell_address),
    .cell_glyph(cell_glyph),
    .fill_all(fill_all),
    .last_write(last_write)
);

>>> test/tb_text_terminal_cell_writer.sv
// Self-checking testbench for text_terminal_cell_writer: drives character bytes,
// predicts every cell write from its own cursor model and checks each word.
// Depends on ttcw_pkg and text_terminal_cell_writer.
module tb_text_terminal_cell_writer;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_STOP     = 8;
    localparam int SETTLE_CYC   = 8;
    localparam int LIMIT_CYC    = 400000;
    localparam int PHASE_ITEMS  = 87;
    localparam int HOLD_CYC     = 300;

    localparam int CHAR_W       = ttcw_pkg::CHAR_W;
    localparam int ATTR_W       = ttcw_pkg::ATTR_W;
    localparam int CELL_ADDR_W  = ttcw_pkg::CELL_ADDR_W;

    // One expected cell write
    typedef struct {
        logic [CELL_ADDR_W-1:0] address;
        logic [CHAR_W-1:0]      glyph;
        logic [ATTR_W-1:0]      attr;
        logic                   fill;
        logic                   last;
    } cell_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CHAR_W-1:0]      char_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [CELL_ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0]      cell_glyph;
    logic [ATTR_W-1:0]      cell_attr;
    logic                   fill_all;
    logic                   last_write;
    logic                   cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]      cfg_wr_data = '0;

    // Stimulus and prediction state
    logic [CHAR_W-1:0] chars_to_send[$];
    cell_write_t       expected_writes[$];
    cell_write_t       oldest;
    int unsigned       cur_row = 0;
    int unsigned       cur_col = 0;
    logic [ATTR_W-1:0] text_attr = ttcw_pkg::TEXT_COLOR_RESET;
    int                send_gap_pct = 0;
    int                recv_stall_pct = 0;
    logic              hold_go = 1'b0;
    int                hold_left = HOLD_CYC;
    int                mismatches = 0;
    int                cycle_count = 0;

    text_terminal_cell_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .TAB_STOP(TAB_STOP)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cell_address(cell_address),
        .cell_glyph  (cell_glyph),
        .cell_attr   (cell_attr),
        .fill_all    (fill_all),
        .last_write  (last_write),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYC)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Cursor model
    // ---------------------------------------------------------------
    task automatic push_write(input int unsigned addr,
                              input logic [CHAR_W-1:0] glyph,
                              input logic fill);
        cell_write_t w;
        w.address = CELL_ADDR_W'(addr);
        w.glyph   = glyph;
        w.attr    = text_attr;
        w.fill    = fill;
        w.last    = 1'b0;
        expected_writes.push_back(w);
    endtask

    task automatic to_next_row();
        cur_col = 0;
        cur_row = (cur_row + 1 >= ROWS) ? 0 : cur_row + 1;
    endtask

    // Write at the cursor and advance, wrapping at the line end
    task automatic put_glyph(input logic [CHAR_W-1:0] glyph);
        push_write(cur_row * COLUMNS + cur_col, glyph, 1'b0);
        cur_col = cur_col + 1;
        if (cur_col >= COLUMNS)
            to_next_row();
    endtask

    task automatic predict_char(input logic [CHAR_W-1:0] c);
        int unsigned spaces;
        int          n;
        n = 0;
        case (c)
            ttcw_pkg::CH_LF: to_next_row();
            ttcw_pkg::CH_CR: cur_col = 0;
            ttcw_pkg::CH_TAB:
            begin
                // space count fixed at the start, so a tab may wrap the line
                spaces = TAB_STOP - (cur_col % TAB_STOP);
                if (spaces > ttcw_pkg::MAX_RESULTS)
                    spaces = ttcw_pkg::MAX_RESULTS;
                for (int i = 0; i < spaces; i++)
                    put_glyph(ttcw_pkg::CH_SPACE);
                n = spaces;
            end
            ttcw_pkg::CH_BS:
            begin
                // nothing at the origin
                if (cur_col > 0 || cur_row > 0)
                begin
                    if (cur_col > 0)
                        cur_col = cur_col - 1;
                    else
                    begin
                        cur_row = cur_row - 1;
                        cur_col = COLUMNS - 1;
                    end
                    push_write(cur_row * COLUMNS + cur_col, ttcw_pkg::CH_SPACE, 1'b0);
                    n = 1;
                end
            end
            ttcw_pkg::CH_FF:
            begin
                push_write(0, ttcw_pkg::CH_SPACE, 1'b1);
                cur_row = 0;
                cur_col = 0;
                n = 1;
            end
            default:
            begin
                put_glyph(c);
                n = 1;
            end
        endcase
        if (n > 0)
            expected_writes[expected_writes.size() - 1].last = 1'b1;
    endtask

    task automatic note_failure(input string what);
        if (mismatches < 10)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Driver: offers pending bytes, holds a stalled byte steady
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                char_in  <= chars_to_send.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with one long hold-off once requested
    always @(posedge clk)
    begin
        if (hold_go && hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: predicts on each accepted byte, checks each accepted word
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_char(char_in);
            if (out_valid && !out_stall)
            begin
                if (expected_writes.size() == 0)
                    note_failure($sformatf("unexpected word %0d/%02h/%02h/%b/%b",
                                           cell_address, cell_glyph, cell_attr,
                                           fill_all, last_write));
                else
                begin
                    oldest = expected_writes.pop_front();
                    if (cell_address !== oldest.address || cell_glyph !== oldest.glyph ||
                        cell_attr !== oldest.attr || fill_all !== oldest.fill ||
                        last_write !== oldest.last)
                        note_failure($sformatf(
                            "addr/glyph/attr/fill/last exp %0d/%02h/%02h/%b/%b got %0d/%02h/%02h/%b/%b",
                            oldest.address, oldest.glyph, oldest.attr, oldest.fill,
                            oldest.last, cell_address, cell_glyph, cell_attr, fill_all,
                            last_write));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic wait_drained();
        while (chars_to_send.size() != 0 || in_valid || expected_writes.size() != 0)
            @(negedge clk);
    endtask

    // Idle: drained, then let a newline or return finish inside the block
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        text_attr = value;
        @(negedge clk);
    endtask

    // Mostly plain text with control codes; runs of lines, newlines and
    // backspaces push the cursor across line ends, rows and the screen end
    task automatic add_random_text(input int count);
        int added;
        int pick;
        int run;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                chars_to_send.push_back(CHAR_W'($urandom_range(0, 255)));
                added++;
            end
            else if (pick < 60)
            begin
                chars_to_send.push_back(ttcw_pkg::CH_TAB);
                added++;
            end
            else if (pick < 72)
            begin
                chars_to_send.push_back(ttcw_pkg::CH_LF);
                added++;
            end
            else if (pick < 80)
            begin
                chars_to_send.push_back(ttcw_pkg::CH_BS);
                added++;
            end
            else if (pick < 86)
            begin
                chars_to_send.push_back(ttcw_pkg::CH_CR);
                added++;
            end
            else if (pick < 87)
            begin
                chars_to_send.push_back(ttcw_pkg::CH_FF);
                added++;
            end
            else if (pick < 91)
            begin
                run = $urandom_range(3, 26);
                if (run > count - added)
                    run = count - added;
                repeat (run) chars_to_send.push_back(ttcw_pkg::CH_LF);
                added += run;
            end
            else if (pick < 95)
            begin
                run = $urandom_range(20, 90);
                if (run > count - added)
                    run = count - added;
                repeat (run) chars_to_send.push_back(CHAR_W'($urandom_range(8'h20, 8'h7E)));
                added += run;
            end
            else
            begin
                run = $urandom_range(3, 20);
                if (run > count - added)
                    run = count - added;
                repeat (run) chars_to_send.push_back(ttcw_pkg::CH_BS);
                added += run;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, every control code, the corner cases
        chars_to_send = '{
            ttcw_pkg::CH_FF,             // clear and home
            ttcw_pkg::CH_BS,             // backspace at the origin
            8'h41, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA,
            ttcw_pkg::CH_TAB,            // partial tab
            ttcw_pkg::CH_TAB,            // full tab from a stop
            ttcw_pkg::CH_BS,
            ttcw_pkg::CH_CR,
            ttcw_pkg::CH_LF,
            ttcw_pkg::CH_BS,             // back across to the previous row end
            8'h7A,                       // printable wrapping at the line end
            ttcw_pkg::CH_BS,
            ttcw_pkg::CH_TAB,            // tab wrapping at the line end
            ttcw_pkg::CH_LF,
            ttcw_pkg::CH_FF
        };
        wait_idle();

        // No idling; long receiver hold and a sender pause
        write_attr(8'h00);
        add_random_text(PHASE_ITEMS / 2);
        hold_go = 1'b1;
        wait_drained();
        add_random_text(PHASE_ITEMS - PHASE_ITEMS / 2);
        wait_idle();

        // Sender gaps
        write_attr(8'hFF);
        send_gap_pct   = 53;
        recv_stall_pct = 0;
        add_random_text(PHASE_ITEMS);
        wait_idle();

        // Receiver stalls
        write_attr(ATTR_W'($urandom_range(0, 255)));
        send_gap_pct   = 0;
        recv_stall_pct = 53;
        add_random_text(PHASE_ITEMS);
        wait_idle();

        // Both sides idle
        write_attr(ATTR_W'($urandom_range(0, 255)));
        send_gap_pct   = 27;
        recv_stall_pct = 27;
        add_random_text(PHASE_ITEMS);
        wait_idle();

        repeat (SETTLE_CYC) @(negedge clk);
        if (mismatches == 0 && expected_writes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> text_terminal_cell_writer.f
sv/ttcw_pkg.sv
sv/text_terminal_cell_writer.sv
sv/ttcw_checker.sv
test/tb_text_terminal_cell_writer.sv
